// File: rtl/fxp_iir_pkg.sv
package fxp_iir_pkg;

   localparam int FF_TAPS_DEFAULT    = 10;
   localparam int FB_TAPS_DEFAULT    = 2;
   localparam int WORD_WIDTH_DEFAULT = 16;
   localparam int INT_BITS_DEFAULT   = 11;

   localparam int ACTION_WIDTH    = 2;
   localparam int TAP_INDEX_WIDTH = 4;
   localparam int SAMPLE_WIDTH    = 16;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_SAMPLE   = 2'd0,
      ACT_FF_WRITE = 2'd1,
      ACT_FB_WRITE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // one tap's worth of control, aligned with the memory read data
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic subtract;
   } mac_ctl_type;

endpackage

// File: rtl/fxp_iir_ram.sv
module fxp_iir_ram #(
   parameter int DEPTH = 12,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_word_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem[rd_addr];
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// File: rtl/fxp_iir_mac.sv
module fxp_iir_mac #(
   parameter int WORD_WIDTH = 16,
   parameter int INT_BITS   = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fxp_iir_pkg::mac_ctl_type     ctl,
   input  logic signed [WORD_WIDTH-1:0] coef,
   input  logic signed [WORD_WIDTH-1:0] hist,
   output logic signed [WORD_WIDTH-1:0] sum,
   output logic                         done
);

   import fxp_iir_pkg::*;

   localparam int FRAC_BITS = WORD_WIDTH - INT_BITS;

   mac_ctl_type                    ctl_ff;
   logic signed [2*WORD_WIDTH-1:0] prod_ff;
   logic signed [WORD_WIDTH-1:0]   scaled;
   logic signed [WORD_WIDTH-1:0]   base;
   logic signed [WORD_WIDTH-1:0]   sum_ff;
   logic signed [WORD_WIDTH-1:0]   sum_in;
   logic                           done_ff;

   always_ff @(posedge clock) begin
      prod_ff <= coef * hist;
   end

   // floor the product to the fraction bits; only the wrapped word is kept
   generate
      if (FRAC_BITS >= 0) begin : g_shift_right
         assign scaled = prod_ff[FRAC_BITS +: WORD_WIDTH];
      end else begin : g_shift_left
         localparam int LSHIFT = INT_BITS - WORD_WIDTH;
         assign scaled = WORD_WIDTH'(prod_ff <<< LSHIFT);
      end
   endgenerate

   always_comb begin
      base   = ctl_ff.first ? '0 : sum_ff;
      sum_in = ctl_ff.subtract ? base - scaled : base + scaled;
   end

   always_ff @(posedge clock) begin
      if (ctl_ff.valid) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= ctl_ff.valid & ctl_ff.last;
      end
   end

   assign sum  = sum_ff;
   assign done = done_ff;

endmodule

// File: rtl/fxp_iir_ctrl.sv
module fxp_iir_ctrl #(
   parameter int FF_TAPS    = 10,
   parameter int FB_TAPS    = 2,
   parameter int WORD_WIDTH = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [fxp_iir_pkg::ACTION_WIDTH-1:0]         req_action,
   input  logic [fxp_iir_pkg::TAP_INDEX_WIDTH-1:0]      req_tap_index,
   input  logic signed [fxp_iir_pkg::SAMPLE_WIDTH-1:0]  req_value,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic signed [fxp_iir_pkg::SAMPLE_WIDTH-1:0]  rsp_filtered_sample,
   output logic                                         coef_wr_en,
   output logic [$clog2(FF_TAPS+FB_TAPS)-1:0]           coef_wr_addr,
   output logic [$clog2(FF_TAPS+FB_TAPS)-1:0]           coef_rd_addr,
   output logic                                         hist_wr_en,
   output logic [$clog2(FF_TAPS+FB_TAPS)-1:0]           hist_wr_addr,
   output logic signed [WORD_WIDTH-1:0]                 hist_wr_data,
   output logic [$clog2(FF_TAPS+FB_TAPS)-1:0]           hist_rd_addr,
   output logic signed [WORD_WIDTH-1:0]                 value_word,
   output fxp_iir_pkg::mac_ctl_type                     mac_ctl,
   input  logic signed [WORD_WIDTH-1:0]                 mac_sum,
   input  logic                                         mac_done
);

   import fxp_iir_pkg::*;

   localparam int NTAPS = FF_TAPS + FB_TAPS;
   localparam int AW    = $clog2(NTAPS);
   localparam int AW1   = AW + 1;
   localparam int IPW   = (FF_TAPS > 1) ? $clog2(FF_TAPS) : 1;
   localparam int OPW   = (FB_TAPS > 1) ? $clog2(FB_TAPS) : 1;
   localparam int IDXW  = TAP_INDEX_WIDTH + 1;

   state_type   state_ff, state_in;
   logic [AW-1:0]  k_ff, k_in;
   logic [IPW-1:0] in_ptr_ff, in_ptr_in, in_ptr_dec;
   logic [OPW-1:0] out_ptr_ff, out_ptr_in, out_ptr_dec;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   mac_ctl_type issue, rd_ctl_ff;

   logic            slot_free;
   logic            is_sample;
   logic            last_tap;
   logic            fb_tap;
   logic [IDXW-1:0] idx_ext;
   logic [AW1-1:0]  k_ext, in_pos, out_pos;

   assign value_word = WORD_WIDTH'(req_value);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign is_sample  = req_action == ACT_SAMPLE;
   assign last_tap   = k_ff == AW'(NTAPS - 1);
   assign fb_tap     = AW1'(k_ff) >= AW1'(FF_TAPS);
   assign idx_ext    = IDXW'(req_tap_index);
   assign k_ext      = AW1'(k_ff);

   assign in_ptr_dec  = (in_ptr_ff == '0) ? IPW'(FF_TAPS - 1) : in_ptr_ff - 1'b1;
   assign out_ptr_dec = (out_ptr_ff == '0) ? OPW'(FB_TAPS - 1) : out_ptr_ff - 1'b1;

   // ring positions: newest word sits at the pointer, older ones follow it
   always_comb begin
      in_pos = AW1'(in_ptr_ff) + k_ext;
      if (in_pos >= AW1'(FF_TAPS)) begin
         in_pos = in_pos - AW1'(FF_TAPS);
      end
      out_pos = AW1'(out_ptr_ff) + k_ext - AW1'(FF_TAPS);
      if (out_pos >= AW1'(FB_TAPS)) begin
         out_pos = out_pos - AW1'(FB_TAPS);
      end
   end

   assign coef_rd_addr = k_ff;
   assign hist_rd_addr = fb_tap ? AW'(out_pos + AW1'(FF_TAPS)) : AW'(in_pos);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && is_sample) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      coef_wr_en    = 1'b0;
      coef_wr_addr  = AW'(idx_ext);
      hist_wr_en    = 1'b0;
      hist_wr_addr  = AW'(in_ptr_dec);
      hist_wr_data  = value_word;
      issue         = '0;
      k_in          = k_ff;
      in_ptr_in     = in_ptr_ff;
      out_ptr_in    = out_ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            k_in      = '0;
            if (req_valid) begin
               priority if (req_action == ACT_SAMPLE) begin
                  hist_wr_en = 1'b1;
                  in_ptr_in  = in_ptr_dec;
               end else if (req_action == ACT_FF_WRITE) begin
                  coef_wr_en = idx_ext < IDXW'(FF_TAPS);
               end else if (req_action == ACT_FB_WRITE) begin
                  coef_wr_en   = idx_ext < IDXW'(FB_TAPS);
                  coef_wr_addr = AW'(idx_ext + IDXW'(FF_TAPS));
               end else begin
                  // unused code: take the word, drop it
                  coef_wr_en = 1'b0;
               end
            end
         end
         ST_READ: begin
            issue.valid    = 1'b1;
            issue.first    = k_ff == '0;
            issue.last     = last_tap;
            issue.subtract = fb_tap;
            k_in           = k_ff + 1'b1;
         end
         ST_DRAIN: begin
            k_in = '0;
         end
         ST_FINISH: begin
            if (slot_free) begin
               hist_wr_en    = 1'b1;
               hist_wr_addr  = AW'(AW1'(out_ptr_dec) + AW1'(FF_TAPS));
               hist_wr_data  = mac_sum;
               out_ptr_in    = out_ptr_dec;
               rsp_valid_in  = 1'b1;
               rsp_sample_in = SAMPLE_WIDTH'(mac_sum);
            end
         end
         default: k_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         in_ptr_ff    <= '0;
         out_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ctl_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         in_ptr_ff    <= in_ptr_in;
         out_ptr_ff   <= out_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ctl_ff    <= issue;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
   end

   assign mac_ctl             = rd_ctl_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;

endmodule

// File: rtl/fixed_point_iir_filter.sv
// Direct-form-I IIR filter in signed fixed point.
// Input channel (req_): each word carries an action, a tap index and a value.
//   A sample word is filtered and yields one rsp_ word; a feedforward or
//   feedback coefficient write updates one tap and yields nothing; a write to
//   a tap beyond the tap count, or an unused action code, is taken and dropped.
// Output channel (rsp_): one filtered sample per sample word, in order.
// A sample word is worked on to the end before another word is accepted:
//   req_ready stays low from its acceptance until its result is written to
//   the output register. The single multiply-accumulate unit steps once per
//   tap through the coefficient and history memories; each tap passes the
//   memory read, product and accumulate registers. Coefficient writes leave
//   the sequencer idle, so req_ready stays high through them.
// Reset clears the sequencer and the valid bits of both memories, so every
//   coefficient and history word reads as zero until written; no sweep is needed.
// When the receiver stalls, the finished sample holds in the output register;
//   the next word may still be accepted and worked on, and its result waits
//   until the register is free, with req_ready low meanwhile.
module fixed_point_iir_filter #(
   parameter int FF_TAPS    = fxp_iir_pkg::FF_TAPS_DEFAULT,
   parameter int FB_TAPS    = fxp_iir_pkg::FB_TAPS_DEFAULT,
   parameter int WORD_WIDTH = fxp_iir_pkg::WORD_WIDTH_DEFAULT,
   parameter int INT_BITS   = fxp_iir_pkg::INT_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [fxp_iir_pkg::ACTION_WIDTH-1:0]        req_action,
   input  logic [fxp_iir_pkg::TAP_INDEX_WIDTH-1:0]     req_tap_index,
   input  logic signed [fxp_iir_pkg::SAMPLE_WIDTH-1:0] req_value,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [fxp_iir_pkg::SAMPLE_WIDTH-1:0] rsp_filtered_sample
);

   import fxp_iir_pkg::*;

   localparam int NTAPS = FF_TAPS + FB_TAPS;
   localparam int AW    = $clog2(NTAPS);

   logic                         coef_wr_en;
   logic [AW-1:0]                coef_wr_addr;
   logic [AW-1:0]                coef_rd_addr;
   logic signed [WORD_WIDTH-1:0] coef_rd_data;
   logic                         hist_wr_en;
   logic [AW-1:0]                hist_wr_addr;
   logic signed [WORD_WIDTH-1:0] hist_wr_data;
   logic [AW-1:0]                hist_rd_addr;
   logic signed [WORD_WIDTH-1:0] hist_rd_data;
   logic signed [WORD_WIDTH-1:0] value_word;
   mac_ctl_type                  mac_ctl;
   logic signed [WORD_WIDTH-1:0] mac_sum;
   logic                         mac_done;

   fxp_iir_ctrl #(
      .FF_TAPS    (FF_TAPS),
      .FB_TAPS    (FB_TAPS),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_tap_index       (req_tap_index),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_filtered_sample (rsp_filtered_sample),
      .coef_wr_en          (coef_wr_en),
      .coef_wr_addr        (coef_wr_addr),
      .coef_rd_addr        (coef_rd_addr),
      .hist_wr_en          (hist_wr_en),
      .hist_wr_addr        (hist_wr_addr),
      .hist_wr_data        (hist_wr_data),
      .hist_rd_addr        (hist_rd_addr),
      .value_word          (value_word),
      .mac_ctl             (mac_ctl),
      .mac_sum             (mac_sum),
      .mac_done            (mac_done)
   );

   // feedforward taps first, feedback taps after them
   fxp_iir_ram #(
      .DEPTH (NTAPS),
      .WIDTH (WORD_WIDTH)
   ) u_coef_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (value_word),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   // input history ring, then output history ring
   fxp_iir_ram #(
      .DEPTH (NTAPS),
      .WIDTH (WORD_WIDTH)
   ) u_hist_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   fxp_iir_mac #(
      .WORD_WIDTH (WORD_WIDTH),
      .INT_BITS   (INT_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .coef  (coef_rd_data),
      .hist  (hist_rd_data),
      .sum   (mac_sum),
      .done  (mac_done)
   );

endmodule
